// File: rtl/affine_point_size_rect_transform_defines.svh
// Assertion macros shared by the affine transform checker.
// Depends on nothing; included by rtl/apsr_checker.sv.
`ifndef AFFINE_POINT_SIZE_RECT_TRANSFORM_DEFINES_SVH
`define AFFINE_POINT_SIZE_RECT_TRANSFORM_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define APSR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define APSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/apsr_pkg.sv
// Shared constants and types for the affine point/size/rect transform.
// Used by the top level and the checker; depends on nothing.
`default_nettype none

package apsr_pkg;

    // default geometry: signed Q16.16 coordinates
    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // operation codes
    localparam int OP_BITS = 2;
    typedef logic [OP_BITS-1:0] t_opcode;
    localparam t_opcode OP_POINT    = 2'd0;
    localparam t_opcode OP_SIZE     = 2'd1;
    localparam t_opcode OP_RECT     = 2'd2;
    localparam t_opcode OP_RESERVED = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 3;
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_COEF_A  = 3'd0;
    localparam t_cfg_idx REG_COEF_B  = 3'd1;
    localparam t_cfg_idx REG_COEF_C  = 3'd2;
    localparam t_cfg_idx REG_COEF_D  = 3'd3;
    localparam t_cfg_idx REG_SHIFT_X = 3'd4;
    localparam t_cfg_idx REG_SHIFT_Y = 3'd5;

endpackage

`default_nettype wire

// File: rtl/affine_point_size_rect_transform.sv
// Affine transform of points, sizes and rectangle bounding boxes, signed fixed point.
// Depends on rtl/apsr_pkg.sv.
//
//   channel   direction   handshake                 payload
//   config    in          i_cfg_we                  i_cfg_index, i_cfg_data
//   request   in          i_in_valid / o_in_stall   i_opcode, i_pos_x/y, i_extent_w/h
//   result    out         o_out_valid / i_out_stall o_out_x/y, o_out_w/h, o_overflow
//
// One request accepted per clock while o_in_stall is low; o_out_valid rises once the
// request has passed through each stage register into the output register.
// Pipeline: operand register, eight parallel multipliers, corner min/max, sums,
// then difference and saturation into the output register.
// Synchronous active-low reset clears all valids and loads the identity matrix.
// Each stage holds while the stage after it is full and stalled; o_in_stall only
// rises when every stage is occupied and the output is stalled.
`default_nettype none

module affine_point_size_rect_transform #(
    parameter int COORD_BITS = apsr_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = apsr_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [apsr_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [COORD_BITS-1:0]              i_cfg_data,
    // request channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [apsr_pkg::OP_BITS-1:0]       i_opcode,
    input  logic signed [COORD_BITS-1:0]       i_pos_x,
    input  logic signed [COORD_BITS-1:0]       i_pos_y,
    input  logic [COORD_BITS-2:0]              i_extent_w,
    input  logic [COORD_BITS-2:0]              i_extent_h,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [COORD_BITS-1:0]       o_out_x,
    output logic signed [COORD_BITS-1:0]       o_out_y,
    output logic [COORD_BITS-2:0]              o_out_w,
    output logic [COORD_BITS-2:0]              o_out_h,
    output logic                               o_overflow
);
    import apsr_pkg::*;

    // operand, full product, sum and difference widths
    localparam int OW = COORD_BITS + 1;
    localparam int MW = COORD_BITS + OW;
    localparam int SW = MW + 2;
    localparam int DW = SW + 1;

    localparam logic signed [COORD_BITS-1:0] ONE_Q  = COORD_BITS'(1) << FRAC_BITS;
    localparam logic signed [COORD_BITS-1:0] SMIN_Q = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic signed [COORD_BITS-1:0] SMAX_Q = {1'b0, {(COORD_BITS-1){1'b1}}};

    // configuration registers
    logic signed [COORD_BITS-1:0] r_coef_a, r_coef_b, r_coef_c, r_coef_d;
    logic signed [COORD_BITS-1:0] r_shift_x, r_shift_y;

    // stage valids and ready chain
    logic r_v0, r_v1, r_v2, r_v3, r_v4;
    logic w_rdy0, w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    // stage 0: operands
    t_opcode                r_op0;
    logic signed [OW-1:0]   r_xa, r_xb, r_ya, r_yb;
    logic signed [OW-1:0]   w_x_ext, w_y_ext, w_w_ext, w_h_ext;
    logic signed [OW-1:0]   n_xa, n_xb, n_ya, n_yb;

    // stage 1: floored products
    t_opcode                   r_op1;
    logic signed [COORD_BITS-1:0] w_lane_coef [8];
    logic signed [OW-1:0]      w_lane_opnd [8];
    logic signed [MW-1:0]      w_full      [8];
    logic signed [MW-1:0]      n_prod      [8];
    logic signed [MW-1:0]      r_prod      [8];

    // stage 2: per-term minimum and maximum over the two corners
    t_opcode                r_op2;
    logic signed [MW-1:0]   n_tmin [4];
    logic signed [MW-1:0]   n_tmax [4];
    logic signed [MW-1:0]   r_tmin [4];
    logic signed [MW-1:0]   r_tmax [4];

    // stage 3: box extremes
    t_opcode                      r_op3;
    logic signed [COORD_BITS-1:0] w_sx, w_sy;
    logic signed [SW-1:0]         n_lo_x, n_hi_x, n_lo_y, n_hi_y;
    logic signed [SW-1:0]         r_lo_x, r_hi_x, r_lo_y, r_hi_y;

    // stage 4: saturation into the output register
    logic signed [DW-1:0]         w_dx, w_dy;
    logic                         w_ovx, w_ovy, w_ovw, w_ovh;
    logic signed [COORD_BITS-1:0] w_satx, w_saty;
    logic [COORD_BITS-2:0]        w_satw, w_sath;
    logic signed [COORD_BITS-1:0] n_out_x, n_out_y, r_out_x, r_out_y;
    logic [COORD_BITS-2:0]        n_out_w, n_out_h, r_out_w, r_out_h;
    logic                         n_ovf, r_ovf;

    // configuration writes, indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a  <= ONE_Q;
            r_coef_b  <= '0;
            r_coef_c  <= '0;
            r_coef_d  <= ONE_Q;
            r_shift_x <= '0;
            r_shift_y <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_COEF_A:  r_coef_a  <= $signed(i_cfg_data);
                REG_COEF_B:  r_coef_b  <= $signed(i_cfg_data);
                REG_COEF_C:  r_coef_c  <= $signed(i_cfg_data);
                REG_COEF_D:  r_coef_d  <= $signed(i_cfg_data);
                REG_SHIFT_X: r_shift_x <= $signed(i_cfg_data);
                REG_SHIFT_Y: r_shift_y <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // a stage takes new data when empty or when the next one moves
    assign w_rdy4     = !r_v4 || !i_out_stall;
    assign w_rdy3     = !r_v3 || w_rdy4;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign w_rdy0     = !r_v0 || w_rdy1;
    assign o_in_stall = !w_rdy0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy0) r_v0 <= i_in_valid;
            if (w_rdy1) r_v1 <= r_v0;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    // operand preparation: size mode maps the extents, others the origin
    assign w_x_ext = OW'(i_pos_x);
    assign w_y_ext = OW'(i_pos_y);
    assign w_w_ext = OW'($signed({1'b0, i_extent_w}));
    assign w_h_ext = OW'($signed({1'b0, i_extent_h}));
    assign n_xa    = (i_opcode == OP_SIZE) ? w_w_ext : w_x_ext;
    assign n_ya    = (i_opcode == OP_SIZE) ? w_h_ext : w_y_ext;
    assign n_xb    = w_x_ext + w_w_ext;
    assign n_yb    = w_y_ext + w_h_ext;

    // eight product lanes: a*x, a*(x+w), c*y, c*(y+h), b*x, b*(x+w), d*y, d*(y+h)
    always_comb begin
        w_lane_coef[0] = r_coef_a;  w_lane_opnd[0] = r_xa;
        w_lane_coef[1] = r_coef_a;  w_lane_opnd[1] = r_xb;
        w_lane_coef[2] = r_coef_c;  w_lane_opnd[2] = r_ya;
        w_lane_coef[3] = r_coef_c;  w_lane_opnd[3] = r_yb;
        w_lane_coef[4] = r_coef_b;  w_lane_opnd[4] = r_xa;
        w_lane_coef[5] = r_coef_b;  w_lane_opnd[5] = r_xb;
        w_lane_coef[6] = r_coef_d;  w_lane_opnd[6] = r_ya;
        w_lane_coef[7] = r_coef_d;  w_lane_opnd[7] = r_yb;
        for (int k = 0; k < 8; k++) begin
            w_full[k] = MW'(w_lane_coef[k]) * MW'(w_lane_opnd[k]);
            // floor to the fraction width
            n_prod[k] = w_full[k] >>> FRAC_BITS;
        end
    end

    // each output term depends on one corner coordinate only, so the box
    // extremes are sums of per-term extremes
    always_comb begin
        for (int p = 0; p < 4; p++) begin
            n_tmin[p] = r_prod[2*p];
            n_tmax[p] = r_prod[2*p];
            if (r_op1 == OP_RECT) begin
                if (r_prod[2*p+1] < r_prod[2*p]) n_tmin[p] = r_prod[2*p+1];
                if (r_prod[2*p+1] > r_prod[2*p]) n_tmax[p] = r_prod[2*p+1];
            end
        end
    end

    // sums with translation, none in size mode
    assign w_sx   = (r_op2 == OP_SIZE) ? '0 : r_shift_x;
    assign w_sy   = (r_op2 == OP_SIZE) ? '0 : r_shift_y;
    assign n_lo_x = SW'(r_tmin[0]) + SW'(r_tmin[1]) + SW'(w_sx);
    assign n_hi_x = SW'(r_tmax[0]) + SW'(r_tmax[1]) + SW'(w_sx);
    assign n_lo_y = SW'(r_tmin[2]) + SW'(r_tmin[3]) + SW'(w_sy);
    assign n_hi_y = SW'(r_tmax[2]) + SW'(r_tmax[3]) + SW'(w_sy);

    // signed saturation of the origin
    assign w_ovx  = !((&r_lo_x[SW-1:COORD_BITS-1]) || !(|r_lo_x[SW-1:COORD_BITS-1]));
    assign w_ovy  = !((&r_lo_y[SW-1:COORD_BITS-1]) || !(|r_lo_y[SW-1:COORD_BITS-1]));
    assign w_satx = w_ovx ? (r_lo_x[SW-1] ? SMIN_Q : SMAX_Q) : r_lo_x[COORD_BITS-1:0];
    assign w_saty = w_ovy ? (r_lo_y[SW-1] ? SMIN_Q : SMAX_Q) : r_lo_y[COORD_BITS-1:0];

    // box extents are never negative, so only the top clamps
    assign w_dx   = DW'(r_hi_x) - DW'(r_lo_x);
    assign w_dy   = DW'(r_hi_y) - DW'(r_lo_y);
    assign w_ovw  = |w_dx[DW-1:COORD_BITS-1];
    assign w_ovh  = |w_dy[DW-1:COORD_BITS-1];
    assign w_satw = w_ovw ? '1 : w_dx[COORD_BITS-2:0];
    assign w_sath = w_ovh ? '1 : w_dy[COORD_BITS-2:0];

    // result selection by mode, reserved code gives all zero
    always_comb begin
        n_out_x = '0;
        n_out_y = '0;
        n_out_w = '0;
        n_out_h = '0;
        n_ovf   = 1'b0;
        unique case (r_op3)
            OP_POINT, OP_SIZE: begin
                n_out_x = w_satx;
                n_out_y = w_saty;
                n_ovf   = w_ovx || w_ovy;
            end
            OP_RECT: begin
                n_out_x = w_satx;
                n_out_y = w_saty;
                n_out_w = w_satw;
                n_out_h = w_sath;
                n_ovf   = w_ovx || w_ovy || w_ovw || w_ovh;
            end
            default: ;
        endcase
    end

    // pipeline payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_rdy0) begin
            r_op0 <= i_opcode;
            r_xa  <= n_xa;
            r_xb  <= n_xb;
            r_ya  <= n_ya;
            r_yb  <= n_yb;
        end
        if (w_rdy1) begin
            r_op1 <= r_op0;
            for (int k = 0; k < 8; k++) begin
                r_prod[k] <= n_prod[k];
            end
        end
        if (w_rdy2) begin
            r_op2 <= r_op1;
            for (int p = 0; p < 4; p++) begin
                r_tmin[p] <= n_tmin[p];
                r_tmax[p] <= n_tmax[p];
            end
        end
        if (w_rdy3) begin
            r_op3  <= r_op2;
            r_lo_x <= n_lo_x;
            r_hi_x <= n_hi_x;
            r_lo_y <= n_lo_y;
            r_hi_y <= n_hi_y;
        end
        if (w_rdy4) begin
            r_out_x <= n_out_x;
            r_out_y <= n_out_y;
            r_out_w <= n_out_w;
            r_out_h <= n_out_h;
            r_ovf   <= n_ovf;
        end
    end

    assign o_out_valid = r_v4;
    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;
    assign o_out_w     = r_out_w;
    assign o_out_h     = r_out_h;
    assign o_overflow  = r_ovf;

endmodule

`default_nettype wire

// File: rtl/apsr_checker.sv
// Port-level checker for the affine transform, bound to the top level below.
// Depends on rtl/apsr_pkg.sv and affine_point_size_rect_transform_defines.svh.
`default_nettype none
`include "affine_point_size_rect_transform_defines.svh"

module apsr_checker #(
    parameter int COORD_BITS = apsr_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [apsr_pkg::OP_BITS-1:0]  i_opcode,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [COORD_BITS-1:0]         i_out_x,
    input  logic [COORD_BITS-1:0]         i_out_y,
    input  logic [COORD_BITS-2:0]         i_out_w,
    input  logic [COORD_BITS-2:0]         i_out_h,
    input  logic                          i_overflow
);
    import apsr_pkg::*;

    // an empty output register means every stage can move
    `APSR_ASSERT_SAME(a_no_stall_when_empty, i_clk, i_rst_n, !i_out_valid, !i_in_stall, "apsr request stalled with output register empty")

    // an accepted request reaches the output when the result side does not stall
    `APSR_ASSERT_NEXT(a_latency, i_clk, i_rst_n, i_in_valid && !i_in_stall ##1 !i_out_stall ##1 !i_out_stall ##1 !i_out_stall ##1 !i_out_stall, i_out_valid, "apsr result missing after pipeline latency")

    // reserved opcode yields an all-zero result
    `APSR_ASSERT_NEXT(a_reserved_zero, i_clk, i_rst_n, i_in_valid && !i_in_stall && i_opcode == OP_RESERVED ##1 !i_out_stall ##1 !i_out_stall ##1 !i_out_stall ##1 !i_out_stall, i_out_valid && i_out_x == '0 && i_out_y == '0 && i_out_w == '0 && i_out_h == '0 && !i_overflow, "apsr reserved opcode gave a non-zero result")

    // a stalled result holds
    `APSR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid && $stable(i_out_x) && $stable(i_out_y) && $stable(i_out_w) && $stable(i_out_h) && $stable(i_overflow), "apsr stalled result changed")

endmodule

bind affine_point_size_rect_transform apsr_checker #(
    .COORD_BITS (COORD_BITS)
) u_apsr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_opcode    (i_opcode),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_x     (o_out_x),
    .i_out_y     (o_out_y),
    .i_out_w     (o_out_w),
    .i_out_h     (o_out_h),
    .i_overflow  (o_overflow)
);

`default_nettype wire
